FILE: rtl/mksts_pkg.sv
// Shared types and constants for the multikey sorted table search unit.
package mksts_pkg;

    localparam int MAX_ENTRIES_DEF = 1024;
    localparam int NUM_KEYS_DEF    = 4;
    localparam int KEY_WIDTH_DEF   = 32;

    localparam int IN_KEY_FIELDS = 4;
    localparam int FIELD_W       = 32;
    localparam int CMD_W         = 2;
    localparam int KIU_W         = 3;
    localparam int IDX_W         = 11;
    localparam int S_TDATA_W     = IN_KEY_FIELDS * FIELD_W;
    localparam int S_TUSER_W     = CMD_W;
    localparam int M_TDATA_W     = 16;
    localparam int M_TUSER_W     = 1;

    localparam logic [KIU_W-1:0] KEYS_IN_USE_RESET = 3'd4;

    typedef enum logic [CMD_W-1:0] {
        CMD_CLEAR  = 2'd0,
        CMD_APPEND = 2'd1,
        CMD_QUERY  = 2'd2
    } cmd_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_LOWER,
        ST_UPPER
    } state_t;

endpackage

FILE: rtl/multikey_sorted_table_search_unit.sv
// Multikey sorted table search unit: table memory, bound search sequencer, result register.
// Clear and append give no result; an append writes a whole entry.
// A query is accepted, then for each compared component a lower and an upper bound search runs
// as halving steps plus a final step (a miss in the lower search ends the query); the registered
// table read, addressed from the next search range, gives each step its midpoint entry.
// Reset clears the entry count and the result valid and sets keys_in_use to 4; table contents
// are undefined until appended, with no clearing pass.
module multikey_sorted_table_search_unit #(
    parameter int MAX_ENTRIES = mksts_pkg::MAX_ENTRIES_DEF,
    parameter int NUM_KEYS    = mksts_pkg::NUM_KEYS_DEF,
    parameter int KEY_WIDTH   = mksts_pkg::KEY_WIDTH_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    // key_0, key_1, key_2, key_3
    input  logic [mksts_pkg::S_TDATA_W-1:0]  s_tdata,
    // cmd
    input  logic [mksts_pkg::S_TUSER_W-1:0]  s_tuser,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // match_index, zero fill
    output logic [mksts_pkg::M_TDATA_W-1:0]  m_tdata,
    // found
    output logic [mksts_pkg::M_TUSER_W-1:0]  m_tuser,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    input  logic [mksts_pkg::KIU_W-1:0]      cfg_data,
    input  logic                             cfg_valid,
    output logic                             cfg_ready
);
    import mksts_pkg::*;

    localparam int CNT_W  = $clog2(MAX_ENTRIES + 1);
    localparam int ADDR_W = $clog2(MAX_ENTRIES);
    localparam int KI_W   = (NUM_KEYS > 1) ? $clog2(NUM_KEYS) : 1;

    typedef logic [NUM_KEYS-1:0][KEY_WIDTH-1:0] entry_t;

    entry_t                  mem [MAX_ENTRIES];
    entry_t                  rdata_reg;
    logic                    we;
    logic [ADDR_W-1:0]       waddr;
    logic [ADDR_W-1:0]       raddr;

    state_t                  state_reg, state_next;
    logic [CNT_W-1:0]        count_reg, count_next;
    logic [KIU_W-1:0]        kiu_reg;
    logic [CNT_W-1:0]        lo_reg, lo_next;
    logic [CNT_W-1:0]        hi_reg, hi_next;
    logic [CNT_W-1:0]        end_reg, end_next;
    logic [CNT_W-1:0]        base_reg, base_next;
    logic [KI_W-1:0]         comp_reg, comp_next;
    logic [KI_W-1:0]         last_reg, last_next;
    entry_t                  key_reg, key_next;
    logic                    ovalid_reg, ovalid_next;
    logic [CNT_W-1:0]        oidx_reg, oidx_next;
    logic                    ofound_reg, ofound_next;

    logic [FIELD_W-1:0]      fields [IN_KEY_FIELDS];
    entry_t                  key_in;
    cmd_t                    cmd;
    logic                    accept;
    logic [3:0]              ncomp;
    logic [CNT_W-1:0]        mid_cur, mid_nxt;
    logic                    open;
    logic [KEY_WIDTH-1:0]    tval, kval;
    logic                    lt, le, eq, miss, last, out_free;

    always_comb
    begin
        for (int f = 0; f < IN_KEY_FIELDS; f++)
        begin
            fields[f] = s_tdata[f*FIELD_W +: FIELD_W];
        end
        for (int c = 0; c < NUM_KEYS; c++)
        begin
            if (c < IN_KEY_FIELDS)
                key_in[c] = KEY_WIDTH'(fields[c % IN_KEY_FIELDS]);
            else
                key_in[c] = '0;
        end
    end

    assign cmd      = cmd_t'(s_tuser);
    assign accept   = s_tvalid && s_tready;
    assign out_free = !ovalid_reg || m_tready;

    always_comb
    begin
        if (kiu_reg == '0)
            ncomp = 4'd1;
        else if (4'(kiu_reg) > 4'(NUM_KEYS))
            ncomp = 4'(NUM_KEYS);
        else
            ncomp = 4'(kiu_reg);
    end

    assign mid_cur = lo_reg + ((hi_reg - lo_reg) >> 1);
    assign open    = lo_reg < hi_reg;
    assign tval    = rdata_reg[comp_reg];
    assign kval    = key_reg[comp_reg];
    assign lt      = tval < kval;
    assign le      = tval <= kval;
    assign eq      = tval == kval;
    assign miss    = (lo_reg >= end_reg) || !eq;
    assign last    = comp_reg == last_reg;

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept && cmd == CMD_QUERY)
                    state_next = ST_LOWER;
            end
            ST_LOWER:
            begin
                if (!open)
                begin
                    if (!miss)
                        state_next = ST_UPPER;
                    else if (out_free)
                        state_next = ST_IDLE;
                end
            end
            ST_UPPER:
            begin
                if (!open)
                begin
                    if (!last)
                        state_next = ST_LOWER;
                    else if (out_free)
                        state_next = ST_IDLE;
                end
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb
    begin
        count_next  = count_reg;
        lo_next     = lo_reg;
        hi_next     = hi_reg;
        end_next    = end_reg;
        base_next   = base_reg;
        comp_next   = comp_reg;
        last_next   = last_reg;
        key_next    = key_reg;
        ovalid_next = ovalid_reg && !m_tready;
        oidx_next   = oidx_reg;
        ofound_next = ofound_reg;
        we          = 1'b0;
        waddr       = count_reg[ADDR_W-1:0];
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    case (cmd)
                        CMD_CLEAR:
                            count_next = '0;
                        CMD_APPEND:
                        begin
                            if (count_reg < CNT_W'(MAX_ENTRIES))
                            begin
                                we         = 1'b1;
                                count_next = count_reg + 1'b1;
                            end
                        end
                        CMD_QUERY:
                        begin
                            lo_next   = '0;
                            hi_next   = count_reg;
                            end_next  = count_reg;
                            comp_next = '0;
                            last_next = KI_W'(ncomp - 4'd1);
                            key_next  = key_in;
                        end
                        default:
                            ;
                    endcase
                end
            end
            ST_LOWER, ST_UPPER:
            begin
                if (open)
                begin
                    if ((state_reg == ST_LOWER) ? lt : le)
                        lo_next = mid_cur + 1'b1;
                    else
                        hi_next = mid_cur;
                end
                else if (state_reg == ST_LOWER)
                begin
                    if (!miss)
                    begin
                        base_next = lo_reg;
                        hi_next   = end_reg;
                    end
                    else if (out_free)
                    begin
                        ovalid_next = 1'b1;
                        oidx_next   = count_reg;
                        ofound_next = 1'b0;
                    end
                end
                else
                begin
                    if (!last)
                    begin
                        comp_next = KI_W'(comp_reg + 1'b1);
                        lo_next   = base_reg;
                        hi_next   = lo_reg;
                        end_next  = lo_reg;
                    end
                    else if (out_free)
                    begin
                        ovalid_next = 1'b1;
                        oidx_next   = base_reg;
                        ofound_next = 1'b1;
                    end
                end
            end
            default:
                ;
        endcase
    end

    assign mid_nxt = lo_next + ((hi_next - lo_next) >> 1);
    assign raddr   = mid_nxt[ADDR_W-1:0];

    assign s_tready  = state_reg == ST_IDLE;
    assign cfg_ready = 1'b1;
    assign m_tvalid  = ovalid_reg;
    assign m_tdata   = M_TDATA_W'(IDX_W'(oidx_reg));
    assign m_tuser   = ofound_reg;

    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= key_in;
        rdata_reg <= mem[raddr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            count_reg  <= '0;
            kiu_reg    <= KEYS_IN_USE_RESET;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            count_reg  <= count_next;
            ovalid_reg <= ovalid_next;
            if (cfg_valid && cfg_ready)
                kiu_reg <= cfg_data;
        end
    end

    always_ff @(posedge clk)
    begin
        lo_reg     <= lo_next;
        hi_reg     <= hi_next;
        end_reg    <= end_next;
        base_reg   <= base_next;
        comp_reg   <= comp_next;
        last_reg   <= last_next;
        key_reg    <= key_next;
        oidx_reg   <= oidx_next;
        ofound_reg <= ofound_next;
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(MAX_ENTRIES))
        else $error("entry count above capacity");

    a_range_order: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_IDLE) |-> (lo_reg <= hi_reg && hi_reg <= end_reg))
        else $error("search range out of order");

    a_range_in_table: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_IDLE) |-> (end_reg <= count_reg))
        else $error("search range beyond entry count");

    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (ovalid_reg && !m_tready) |=> (ovalid_reg && $stable(oidx_reg)))
        else $error("pending result overwritten");

endmodule

FILE: bench/multikey_sorted_table_search_unit_tb.sv
// Testbench for multikey_sorted_table_search_unit: directed rows, then random loads and queries.
module multikey_sorted_table_search_unit_tb;
    import mksts_pkg::*;

    localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
    localparam int NK           = NUM_KEYS_DEF;
    localparam int DEPTH        = MAX_ENTRIES_DEF;
    localparam int HOLD_CYCLES  = 400;
    localparam int DRAIN_CYCLES = 60;
    localparam int CYCLE_LIMIT  = 2000000;
    localparam int FILL_ITEMS   = DEPTH + 6;
    localparam int DIR_ROWS     = 23;

    typedef struct packed {
        logic [IDX_W-1:0] index;
        logic             found;
    } search_result_t;

    typedef struct {
        logic [CMD_W-1:0] cmd;
        logic [31:0]      k0;
        logic [31:0]      k1;
        logic [31:0]      k2;
        logic [31:0]      k3;
        bit               typed;
        logic [IDX_W-1:0] index;
        logic             found;
    } dir_row_t;

    logic                 clk = 1'b0;
    logic                 rst_n;
    logic [S_TDATA_W-1:0] s_tdata;
    logic [S_TUSER_W-1:0] s_tuser;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [M_TDATA_W-1:0] m_tdata;
    logic [M_TUSER_W-1:0] m_tuser;
    logic                 m_tvalid;
    logic                 m_tready;
    logic [KIU_W-1:0]     cfg_data;
    logic                 cfg_valid;
    logic                 cfg_ready;

    // search model state
    logic [31:0]      ref_table [DEPTH][NK];
    int unsigned      entry_total;
    logic [KIU_W-1:0] keys_compared;

    search_result_t   pending_results [$];
    bit               next_typed;
    search_result_t   next_typed_result;
    int               burst_left;
    bit               hold_off_request;
    int unsigned      mismatches;
    int unsigned      cycle_count;
    logic [31:0]      fill_k3 [DEPTH];
    dir_row_t         dir_rows [DIR_ROWS];

    multikey_sorted_table_search_unit DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .cfg_data  (cfg_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready)
    );

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("multikey_sorted_table_search_unit verification failed");
            $finish;
        end
    end

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("MISMATCH %s: got %0h expected %0h", what, got, want);
        mismatches++;
    endtask

    function automatic int unsigned bound_pos(input int comp, input logic [31:0] v,
                                              input int unsigned lo_in,
                                              input int unsigned hi_in, input bit upper);
        int unsigned lo;
        int unsigned hi;
        int unsigned mid;
        bit          go_right;
        lo = lo_in;
        hi = hi_in;
        while (lo < hi)
        begin
            mid = lo + (hi - lo) / 2;
            go_right = upper ? (ref_table[mid][comp] <= v) : (ref_table[mid][comp] < v);
            if (go_right)
                lo = mid + 1;
            else
                hi = mid;
        end
        return lo;
    endfunction

    // Applies one accepted item to the model; a query yields a result.
    task automatic search_model_step(input logic [CMD_W-1:0] cmd,
                                     input logic [S_TDATA_W-1:0] keys,
                                     output bit has_result, output search_result_t res);
        int unsigned ncomp;
        int unsigned lo;
        int unsigned hi;
        int unsigned nlo;
        bit          hit;
        logic [31:0] kv;
        has_result = 1'b0;
        res = '0;
        if (cmd == CMD_CLEAR)
            entry_total = 0;
        else if (cmd == CMD_APPEND)
        begin
            if (entry_total < DEPTH)
            begin
                for (int c = 0; c < NK; c++)
                    ref_table[entry_total][c] = keys[c*FIELD_W +: FIELD_W];
                entry_total++;
            end
        end
        else if (cmd == CMD_QUERY)
        begin
            ncomp = keys_compared;
            if (ncomp == 0)
                ncomp = 1;
            if (ncomp > NK)
                ncomp = NK;
            lo = 0;
            hi = entry_total;
            hit = 1'b1;
            for (int c = 0; c < ncomp; c++)
            begin
                kv = keys[c*FIELD_W +: FIELD_W];
                nlo = bound_pos(c, kv, lo, hi, 1'b0);
                if (nlo >= hi || ref_table[nlo][c] != kv)
                begin
                    hit = 1'b0;
                    break;
                end
                hi = bound_pos(c, kv, nlo, hi, 1'b1);
                lo = nlo;
            end
            has_result = 1'b1;
            res.index = IDX_W'(hit ? lo : entry_total);
            res.found = hit;
        end
    endtask

    always @(posedge clk)
    begin
        search_result_t want;
        search_result_t got;
        bit             has_result;
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
            begin
                if (pending_results.size() == 0)
                    report_mismatch("result with no query waiting", 32'(m_tdata), 32'hx);
                else
                begin
                    want = pending_results.pop_front();
                    if (m_tdata != M_TDATA_W'(want.index))
                        report_mismatch("match_index", 32'(m_tdata), 32'(want.index));
                    if (m_tuser[0] != want.found)
                        report_mismatch("found", 32'(m_tuser), 32'(want.found));
                end
            end
            if (s_tvalid && s_tready)
            begin
                search_model_step(s_tuser, s_tdata, has_result, got);
                if (has_result)
                    pending_results.push_back(next_typed ? next_typed_result : got);
            end
        end
    end

    // Result side: stall modes of random length, plus one long hold-off on request.
    initial
    begin
        int mode;
        int mode_left;
        int phase;
        m_tready = 1'b0;
        mode = 0;
        mode_left = 0;
        phase = 0;
        forever
        begin
            @(negedge clk);
            if (hold_off_request)
            begin
                hold_off_request = 1'b0;
                m_tready <= 1'b0;
                for (int n = 0; n < HOLD_CYCLES; n++)
                    @(negedge clk);
            end
            if (mode_left == 0)
            begin
                mode = $urandom_range(0, 3);
                mode_left = $urandom_range(5, 80);
            end
            mode_left--;
            phase++;
            case (mode)
                0: m_tready <= 1'b1;
                1: m_tready <= 1'($urandom_range(0, 1));
                2: m_tready <= ($urandom_range(0, 3) == 0);
                default: m_tready <= (phase % 3 != 0);
            endcase
        end
    end

    task automatic send_item(input logic [CMD_W-1:0] cmd, input logic [S_TDATA_W-1:0] keys,
                             input bit typed, input search_result_t typed_res);
        int gap;
        @(negedge clk);
        if (burst_left == 0)
        begin
            gap = $urandom_range(1, 10);
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(50, 200)
                                                     : $urandom_range(1, 12);
        end
        burst_left--;
        s_tdata <= keys;
        s_tuser <= cmd;
        s_tvalid <= 1'b1;
        next_typed = typed;
        next_typed_result = typed_res;
        do @(posedge clk); while (!s_tready);
    endtask

    task automatic send_plain(input logic [CMD_W-1:0] cmd, input logic [S_TDATA_W-1:0] keys);
        send_item(cmd, keys, 1'b0, '0);
    endtask

    task automatic end_burst();
        @(negedge clk);
        s_tvalid <= 1'b0;
        burst_left = 0;
    endtask

    task automatic wait_drained();
        end_burst();
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_keys_in_use(input logic [KIU_W-1:0] v);
        wait_drained();
        @(negedge clk);
        cfg_data <= v;
        cfg_valid <= 1'b1;
        do @(posedge clk); while (!cfg_ready);
        keys_compared = v;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    function automatic logic [31:0] gen_key(input int style);
        case (style)
            0: return 32'($urandom_range(0, 2));
            1:
            begin
                case ($urandom_range(0, 3))
                    0: return 32'h0000_0000;
                    1: return 32'hFFFF_FFFF;
                    2: return 32'h7FFF_FFFF;
                    default: return 32'h8000_0000;
                endcase
            end
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [S_TDATA_W-1:0] gen_keys(input int style);
        logic [S_TDATA_W-1:0] k;
        for (int c = 0; c < NK; c++)
            k[c*FIELD_W +: FIELD_W] = gen_key(style);
        return k;
    endfunction

    function automatic bit lex_less(input logic [S_TDATA_W-1:0] a,
                                    input logic [S_TDATA_W-1:0] b);
        for (int c = 0; c < NK; c++)
            if (a[c*FIELD_W +: FIELD_W] != b[c*FIELD_W +: FIELD_W])
                return a[c*FIELD_W +: FIELD_W] < b[c*FIELD_W +: FIELD_W];
        return 1'b0;
    endfunction

    // Clear (most of the time), load a small (mostly sorted) table, then query it.
    task automatic run_sequence(input bit with_hold);
        logic [S_TDATA_W-1:0] ent [32];
        logic [S_TDATA_W-1:0] qk;
        logic [S_TDATA_W-1:0] tmp;
        int n;
        int q;
        int j;
        int c;
        int style;
        style = $urandom_range(0, 2);
        if ($urandom_range(0, 9) != 0)
            send_plain(CMD_CLEAR, gen_keys(2));
        n = $urandom_range(0, 16);
        for (int i = 0; i < n; i++)
            ent[i] = ($urandom_range(0, 3) == 0) ? gen_keys($urandom_range(0, 2))
                                                 : gen_keys(style);
        if ($urandom_range(0, 7) != 0)
            for (int i = 1; i < n; i++)
            begin
                tmp = ent[i];
                j = i - 1;
                while (j >= 0 && lex_less(tmp, ent[j]))
                begin
                    ent[j+1] = ent[j];
                    j--;
                end
                ent[j+1] = tmp;
            end
        for (int i = 0; i < n; i++)
        begin
            if ($urandom_range(0, 19) == 0)
                send_plain(CMD_UNUSED, gen_keys(2));
            send_plain(CMD_APPEND, ent[i]);
        end
        if (with_hold)
            hold_off_request = 1'b1;
        q = $urandom_range(8, 24);
        for (int i = 0; i < q; i++)
        begin
            if (n > 0 && $urandom_range(0, 9) < 7)
            begin
                qk = ent[$urandom_range(0, n - 1)];
                if ($urandom_range(0, 2) == 0)
                begin
                    c = $urandom_range(0, NK - 1);
                    case ($urandom_range(0, 2))
                        0: qk[c*FIELD_W +: FIELD_W] = qk[c*FIELD_W +: FIELD_W] + 32'd1;
                        1: qk[c*FIELD_W +: FIELD_W] = qk[c*FIELD_W +: FIELD_W] - 32'd1;
                        default: qk[c*FIELD_W +: FIELD_W] = gen_key(style);
                    endcase
                end
            end
            else
                qk = gen_keys(style);
            if ($urandom_range(0, 19) == 0)
                send_plain(CMD_UNUSED, gen_keys(2));
            send_plain(CMD_QUERY, qk);
        end
    endtask

    function automatic logic [S_TDATA_W-1:0] fill_keys(input int i, input logic [31:0] k3);
        return {k3, 32'(i % 2), 32'((i % 8) / 2), 32'(i / 8)};
    endfunction

    // Full table: the last few appends are dropped.
    task automatic fill_table();
        send_plain(CMD_CLEAR, '0);
        for (int i = 0; i < FILL_ITEMS; i++)
        begin
            if (i < DEPTH)
            begin
                fill_k3[i] = $urandom;
                send_plain(CMD_APPEND, fill_keys(i, fill_k3[i]));
            end
            else
                send_plain(CMD_APPEND, fill_keys(i, $urandom));
        end
    endtask

    task automatic fill_queries(input int count);
        int i;
        send_plain(CMD_QUERY, fill_keys(DEPTH - 1, fill_k3[DEPTH - 1]));
        send_plain(CMD_QUERY, fill_keys(DEPTH, 32'h0));
        send_plain(CMD_QUERY, fill_keys(0, fill_k3[0]));
        for (int n = 0; n < count; n++)
        begin
            i = $urandom_range(0, DEPTH - 1);
            if ($urandom_range(0, 3) == 0)
                send_plain(CMD_QUERY, fill_keys(i, $urandom));
            else
                send_plain(CMD_QUERY, fill_keys(i, fill_k3[i]));
        end
    endtask

    initial
    begin
        logic [KIU_W-1:0] kiu_plan [8];
        search_result_t   typed_res;
        kiu_plan = '{3'd1, 3'd2, 3'd3, 3'd0, 3'd7, 3'd5, 3'd6, 3'd4};
        dir_rows = '{
            '{CMD_QUERY,  32'h0, 32'h0, 32'h0, 32'h0, 1'b1, 11'd0, 1'b0},
            '{CMD_UNUSED, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
              1'b0, 11'd0, 1'b0},
            '{CMD_APPEND, 32'h0, 32'h0, 32'h0, 32'h0, 1'b0, 11'd0, 1'b0},
            '{CMD_APPEND, 32'h0, 32'h0, 32'h0, 32'hFFFF_FFFF, 1'b0, 11'd0, 1'b0},
            '{CMD_APPEND, 32'h0, 32'hFFFF_FFFF, 32'h0, 32'h0, 1'b0, 11'd0, 1'b0},
            '{CMD_APPEND, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
              1'b0, 11'd0, 1'b0},
            '{CMD_QUERY,  32'h0, 32'h0, 32'h0, 32'h0, 1'b1, 11'd0, 1'b1},
            '{CMD_QUERY,  32'h0, 32'h0, 32'h0, 32'hFFFF_FFFF, 1'b1, 11'd1, 1'b1},
            '{CMD_QUERY,  32'h0, 32'hFFFF_FFFF, 32'h0, 32'h0, 1'b1, 11'd2, 1'b1},
            '{CMD_QUERY,  32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
              1'b1, 11'd3, 1'b1},
            '{CMD_QUERY,  32'h0, 32'h0, 32'h0, 32'h1, 1'b1, 11'd4, 1'b0},
            '{CMD_QUERY,  32'h1, 32'h0, 32'h0, 32'h0, 1'b1, 11'd4, 1'b0},
            '{CMD_QUERY,  32'h7FFF_FFFF, 32'h8000_0000, 32'h1, 32'h2, 1'b0, 11'd0, 1'b0},
            '{CMD_APPEND, 32'h0, 32'h0, 32'h0, 32'h0, 1'b0, 11'd0, 1'b0},
            '{CMD_QUERY,  32'h0, 32'h0, 32'h0, 32'h0, 1'b0, 11'd0, 1'b0},
            '{CMD_CLEAR,  32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
              1'b0, 11'd0, 1'b0},
            '{CMD_QUERY,  32'h0, 32'h0, 32'h0, 32'h0, 1'b1, 11'd0, 1'b0},
            '{CMD_APPEND, 32'h5, 32'h5, 32'h5, 32'h5, 1'b0, 11'd0, 1'b0},
            '{CMD_QUERY,  32'h5, 32'h5, 32'h5, 32'h4, 1'b1, 11'd1, 1'b0},
            '{CMD_APPEND, 32'h5, 32'h5, 32'h5, 32'h5, 1'b0, 11'd0, 1'b0},
            '{CMD_QUERY,  32'h5, 32'h5, 32'h5, 32'h5, 1'b1, 11'd0, 1'b1},
            '{CMD_QUERY,  32'h5, 32'h5, 32'h5, 32'h6, 1'b0, 11'd0, 1'b0},
            '{CMD_UNUSED, 32'h0, 32'h0, 32'h0, 32'h0, 1'b0, 11'd0, 1'b0}
        };
        rst_n = 1'b0;
        s_tdata = '0;
        s_tuser = '0;
        s_tvalid = 1'b0;
        cfg_data = '0;
        cfg_valid = 1'b0;
        entry_total = 0;
        keys_compared = KEYS_IN_USE_RESET;
        next_typed = 1'b0;
        next_typed_result = '0;
        burst_left = 0;
        hold_off_request = 1'b0;
        mismatches = 0;
        cycle_count = 0;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        for (int r = 0; r < DIR_ROWS; r++)
        begin
            typed_res.index = dir_rows[r].index;
            typed_res.found = dir_rows[r].found;
            send_item(dir_rows[r].cmd,
                      {dir_rows[r].k3, dir_rows[r].k2, dir_rows[r].k1, dir_rows[r].k0},
                      dir_rows[r].typed, typed_res);
        end

        for (int p = 0; p < 8; p++)
        begin
            write_keys_in_use(kiu_plan[p]);
            run_sequence(p == 0);
        end

        fill_table();
        fill_queries(30);
        write_keys_in_use(3'd1);
        fill_queries(12);
        write_keys_in_use(3'd2);
        fill_queries(12);

        wait_drained();
        if (mismatches == 0)
            $display("multikey_sorted_table_search_unit verification clean");
        else
            $display("multikey_sorted_table_search_unit verification failed");
        $finish;
    end

endmodule
